@@ hdl/iotu_pkg.sv @@
// ----------------------------------------------------------------------------
// iotu_pkg
// Shared types, register offsets, constants and service helpers of the
// I/O controller interrupt/timer unit.
// ----------------------------------------------------------------------------
package iotu_pkg;

  localparam int OP_W       = 3;
  localparam int ADDR_W     = 4;
  localparam int BYTE_W     = 8;
  localparam int NUM_TIMERS = 5;
  localparam int TIDX_W     = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_TICK   = 3'd2,
    OP_SENSOR = 3'd3,
    OP_PIN7   = 3'd4
  } op_t;

  // register offsets
  localparam logic [ADDR_W-1:0] ADDR_SERIAL   = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_PORT_IN  = 4'd1;
  localparam logic [ADDR_W-1:0] ADDR_VECTOR   = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_STATUS   = 4'd3;
  localparam logic [ADDR_W-1:0] ADDR_COMMAND  = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_RATE     = 4'd5;
  localparam logic [ADDR_W-1:0] ADDR_PORT_OUT = 4'd7;
  localparam logic [ADDR_W-1:0] ADDR_MASK     = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_TIMER0   = 4'd9;

  localparam byte_t VEC_BASE      = 8'hC7;
  localparam byte_t CMD_KEEP      = 8'h3E;
  localparam byte_t STATUS_RESET  = 8'h14;
  localparam byte_t PENDING_RESET = 8'h20;
  localparam byte_t SOFT_CLR      = 8'hCA;  // status bits 1, 3, 6, 7
  localparam byte_t SOFT_SET      = 8'h14;  // status bits 2, 4

  // status / command / pending bit positions
  localparam int STAT_SER_BIT  = 3;
  localparam int STAT_INT_BIT  = 5;
  localparam int CMD_SOFT_BIT  = 0;
  localparam int CMD_PIN7_BIT  = 2;
  localparam int CMD_ACK_BIT   = 3;
  localparam int PEND_SENS_BIT = 2;
  localparam int PEND_PIN7_BIT = 7;

  localparam logic [TIDX_W-1:0] TIMER_PIN7 = 3'd4;

  // pending bit of each timer
  localparam logic [NUM_TIMERS-1:0][BYTE_W-1:0] TIMER_BIT =
    {8'h80, 8'h40, 8'h08, 8'h02, 8'h01};

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    byte_t             write_data;
    logic              level;
    byte_t             port_in;
  } in_beat_t;

  typedef struct packed {
    byte_t read_data;
    byte_t port_out;
    logic  port_out_strobe;
    logic  irq_line;
    byte_t irq_vector;
  } out_beat_t;

  typedef struct packed {
    byte_t                         status;
    byte_t                         command;
    byte_t                         mask;
    byte_t                         pending;
    byte_t                         vector;
    byte_t                         rate;
    logic [NUM_TIMERS-1:0][BYTE_W-1:0] period;
    logic [NUM_TIMERS-1:0][BYTE_W-1:0] remaining;
    logic [NUM_TIMERS-1:0]         running;
    logic                          sensor_prev;
    logic                          pin7_prev;
    logic                          irq_level;
    byte_t                         out_latch;
  } ctl_state_t;

  // lowest masked pending bit is served and cleared
  function automatic ctl_state_t service(input ctl_state_t st);
    ctl_state_t        s;
    byte_t             act;
    logic [TIDX_W-1:0] lvl;
    s   = st;
    act = st.pending & st.mask;
    lvl = '0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (act[b]) lvl = TIDX_W'(b);
    end
    if (act != '0) begin
      s.pending[lvl] = 1'b0;
      s.vector       = VEC_BASE + {2'b00, lvl, 3'b000};
      if (st.command[CMD_ACK_BIT]) s.irq_level = 1'b1;
      else s.status[STAT_INT_BIT] = 1'b1;
    end else begin
      if (st.command[CMD_ACK_BIT]) s.irq_level = 1'b0;
      else s.status[STAT_INT_BIT] = 1'b0;
    end
    return s;
  endfunction

  function automatic ctl_state_t timer_fire(input ctl_state_t st,
                                            input logic [TIDX_W-1:0] t);
    ctl_state_t s;
    s = st;
    if (t != TIMER_PIN7 || !st.command[CMD_PIN7_BIT]) s.pending = s.pending | TIMER_BIT[t];
    return service(s);
  endfunction

  function automatic ctl_state_t soft_reset(input ctl_state_t st);
    ctl_state_t s;
    s           = st;
    s.status    = (st.status & ~SOFT_CLR) | SOFT_SET;
    s.pending   = PENDING_RESET;
    s.period    = '0;
    s.remaining = '0;
    s.running   = '0;
    return s;
  endfunction

  function automatic ctl_state_t state_reset();
    ctl_state_t s;
    s         = '0;
    s.status  = STATUS_RESET;
    s.pending = PENDING_RESET;
    return s;
  endfunction

endpackage

@@ hdl/iotu_if.sv @@
// ----------------------------------------------------------------------------
// iotu channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface iotu_in_if;
  logic                          valid;
  logic                          ready;
  logic [iotu_pkg::OP_W-1:0]     operation;
  logic [iotu_pkg::ADDR_W-1:0]   address;
  logic [iotu_pkg::BYTE_W-1:0]   write_data;
  logic                          level;
  logic [iotu_pkg::BYTE_W-1:0]   port_in;

  modport source (output valid, operation, address, write_data, level, port_in,
                  input ready);
  modport sink   (input valid, operation, address, write_data, level, port_in,
                  output ready);
endinterface

interface iotu_out_if;
  logic                          valid;
  logic                          ready;
  logic [iotu_pkg::BYTE_W-1:0]   read_data;
  logic [iotu_pkg::BYTE_W-1:0]   port_out;
  logic                          port_out_strobe;
  logic                          irq_line;
  logic [iotu_pkg::BYTE_W-1:0]   irq_vector;

  modport source (output valid, read_data, port_out, port_out_strobe, irq_line,
                  irq_vector, input ready);
  modport sink   (input valid, read_data, port_out, port_out_strobe, irq_line,
                  irq_vector, output ready);
endinterface

@@ hdl/io_controller_interrupt_timer_unit_core.sv @@
// ----------------------------------------------------------------------------
// io_controller_interrupt_timer_unit_core
// Register-mapped I/O controller: bus registers, five reloading timers,
// edge inputs and a prioritized interrupt vector.
//
// Every request beat (bus read, bus write, timer tick, sensor level or pin-7
// level) gives exactly one result beat. The block takes one beat per cycle
// while the sink does not stall. A request is held in the request register,
// then the whole register update (including up to five timer expiries on
// one tick, each followed by priority service) runs in one pass of logic
// into the state and result registers. The result
// register lets a new request be taken while a result waits; when the sink
// stalls, one more request is held and then in_chan.ready drops. Reads of
// offsets 0 and 2 have side effects on status bits 3 and 5; a command write
// with bit 0 set performs a soft reset of timers, pending bits and status.
// There is no serial path; its receive buffer reads as 0.
// ----------------------------------------------------------------------------
module io_controller_interrupt_timer_unit_core (
  input logic       clk,
  input logic       rst_n,
  iotu_in_if.sink   in_chan,
  iotu_out_if.source out_chan
);
  import iotu_pkg::*;

  // request stage
  logic       req_valid_r;
  in_beat_t   req_beat_r;
  // result stage
  logic       out_valid_r;
  out_beat_t  out_beat_r;
  // controller state
  ctl_state_t st_r;
  ctl_state_t st_nxt;
  out_beat_t  res_nxt;

  logic adv;       // request stage moves into the result stage
  logic in_take;   // request beat accepted

  assign adv          = req_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || adv;
  assign in_take      = in_chan.valid && in_chan.ready;

  iotu_step u_step (
    .st     (st_r),
    .beat   (req_beat_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= state_reset();
    end else begin
      if (in_chan.ready) req_valid_r <= in_chan.valid;
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_beat_r.operation  <= in_chan.operation;
      req_beat_r.address    <= in_chan.address;
      req_beat_r.write_data <= in_chan.write_data;
      req_beat_r.level      <= in_chan.level;
      req_beat_r.port_in    <= in_chan.port_in;
    end
    if (adv) out_beat_r <= res_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.read_data       = out_beat_r.read_data;
  assign out_chan.port_out        = out_beat_r.port_out;
  assign out_chan.port_out_strobe = out_beat_r.port_out_strobe;
  assign out_chan.irq_line        = out_beat_r.irq_line;
  assign out_chan.irq_vector      = out_beat_r.irq_vector;

`ifndef SYNTH
  logic [NUM_TIMERS-1:0] tmr_nz;
  always_comb begin
    for (int t = 0; t < NUM_TIMERS; t++) tmr_nz[t] = st_r.remaining[t] != '0;
  end

  // vector is either untouched or a restart opcode
  a_vector_form: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.vector == '0 || st_r.vector[2:0] == 3'b111)
    else $error("vector is not a restart opcode");

  // soft-reset bit and top command bits never stored
  a_cmd_bits: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.command[CMD_SOFT_BIT] == 1'b0 && st_r.command[7:6] == 2'b00)
    else $error("command holds unkept bits");

  // a running timer never sits at zero
  a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.running & ~tmr_nz) == '0)
    else $error("running timer with zero count");

  // full pipe with stalled sink refuses requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("request taken while both stages are blocked");

  // state moves only with a beat
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("state changed without a beat");
`endif

endmodule

@@ hdl/iotu_step.sv @@
// ----------------------------------------------------------------------------
// iotu_step
// Next-state and result logic for one request beat.
// ----------------------------------------------------------------------------
module iotu_step (
  input  iotu_pkg::ctl_state_t st,
  input  iotu_pkg::in_beat_t   beat,
  output iotu_pkg::ctl_state_t st_nxt,
  output iotu_pkg::out_beat_t  res
);
  import iotu_pkg::*;

  byte_t rd;
  logic  strobe;

  always_comb begin
    st_nxt = st;
    rd     = '0;
    strobe = 1'b0;
    case (op_t'(beat.operation))
      OP_READ: begin
        case (beat.address)
          ADDR_SERIAL:  st_nxt.status[STAT_SER_BIT] = 1'b0;
          ADDR_PORT_IN: rd = beat.port_in;
          ADDR_VECTOR: begin
            rd = st.vector;
            st_nxt.status[STAT_INT_BIT] = 1'b0;
          end
          ADDR_STATUS:  rd = st.status;
          ADDR_COMMAND: rd = st.command;
          ADDR_RATE:    rd = st.rate;
          ADDR_MASK:    rd = st.mask;
          default:      rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (beat.address)
          ADDR_COMMAND: begin
            st_nxt.command = beat.write_data & CMD_KEEP;
            if (beat.write_data[CMD_SOFT_BIT]) st_nxt = soft_reset(st_nxt);
          end
          ADDR_RATE: st_nxt.rate = beat.write_data;
          ADDR_PORT_OUT: begin
            st_nxt.out_latch = beat.write_data;
            strobe           = 1'b1;
          end
          ADDR_MASK: st_nxt.mask = beat.write_data;
          default: begin
            // timer period writes
            for (int t = 0; t < NUM_TIMERS; t++) begin
              if (beat.address == ADDR_TIMER0 + ADDR_W'(t)) begin
                st_nxt.period[t] = beat.write_data;
                if (beat.write_data != '0) begin
                  st_nxt.remaining[t] = beat.write_data;
                  st_nxt.running[t]   = 1'b1;
                end else begin
                  st_nxt.remaining[t] = '0;
                  st_nxt.running[t]   = 1'b0;
                  st_nxt = timer_fire(st_nxt, TIDX_W'(t));
                end
              end
            end
          end
        endcase
      end
      OP_TICK: begin
        // expiries fire in timer order, each one serviced
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (st_nxt.running[t]) begin
            if (st_nxt.remaining[t] > 8'd1) begin
              st_nxt.remaining[t] = st_nxt.remaining[t] - 8'd1;
            end else begin
              st_nxt.remaining[t] = st_nxt.period[t];
              st_nxt = timer_fire(st_nxt, TIDX_W'(t));
            end
          end
        end
      end
      OP_SENSOR: begin
        st_nxt.pending[PEND_SENS_BIT] = !st.sensor_prev && beat.level;
        st_nxt.sensor_prev = beat.level;
        if (st_nxt.pending[PEND_SENS_BIT]) st_nxt = service(st_nxt);
      end
      OP_PIN7: begin
        if (st.command[CMD_PIN7_BIT]) begin
          st_nxt.pending[PEND_PIN7_BIT] = !st.pin7_prev && beat.level;
        end
        st_nxt.pin7_prev = beat.level;
        if (st_nxt.pending[PEND_PIN7_BIT]) st_nxt = service(st_nxt);
      end
      default: st_nxt = st;
    endcase
  end

  assign res.read_data       = rd;
  assign res.port_out        = st_nxt.out_latch;
  assign res.port_out_strobe = strobe;
  assign res.irq_line        = st_nxt.irq_level;
  assign res.irq_vector      = st_nxt.vector;

endmodule

@@ test/io_controller_interrupt_timer_unit_core_tb.sv @@
// ----------------------------------------------------------------------------
// io_controller_interrupt_timer_unit_core_tb
// Self-checking bench for the I/O controller interrupt/timer unit. A
// scoreboard keeps its own copy of the register file, timers and edge
// detectors and predicts the single result beat of every request. Directed
// beats come first, then weighted random traffic, with random gaps on both
// channels, one long sink hold-off and one drain pause.
// ----------------------------------------------------------------------------
module io_controller_interrupt_timer_unit_core_tb;
  import iotu_pkg::*;

  class irq_timer_scoreboard;
    // mirrored controller state
    byte_t     status, command, mask, pending, vector, rate, out_latch;
    byte_t     period[NUM_TIMERS];
    byte_t     remaining[NUM_TIMERS];
    bit        running[NUM_TIMERS];
    bit        sensor_prev, pin7_prev, irq_level;
    out_beat_t expected_results[$];
    int unsigned kind_count[8];
    int unsigned served, checked, mismatches;

    function new();
      status    = STATUS_RESET;
      command   = '0;
      mask      = '0;
      pending   = PENDING_RESET;
      vector    = '0;
      rate      = '0;
      out_latch = '0;
      foreach (period[t]) begin
        period[t]    = '0;
        remaining[t] = '0;
        running[t]   = 1'b0;
      end
      sensor_prev = 1'b0;
      pin7_prev   = 1'b0;
      irq_level   = 1'b0;
      foreach (kind_count[k]) kind_count[k] = 0;
      served     = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    // lowest enabled pending bit wins, else the request is withdrawn
    function void serve_lowest();
      byte_t act;
      int    lvl;
      act = pending & mask;
      lvl = -1;
      for (int b = 0; b < BYTE_W; b++) begin
        if (act[b] && lvl < 0) lvl = b;
      end
      if (lvl >= 0) begin
        pending[lvl] = 1'b0;
        vector       = VEC_BASE + byte_t'(8 * lvl);
        if (command[CMD_ACK_BIT]) irq_level = 1'b1;
        else status[STAT_INT_BIT] = 1'b1;
        served++;
      end else if (command[CMD_ACK_BIT]) begin
        irq_level = 1'b0;
      end else begin
        status[STAT_INT_BIT] = 1'b0;
      end
    endfunction

    function void fire_timer(int t);
      if (t != TIMER_PIN7 || !command[CMD_PIN7_BIT]) pending = pending | TIMER_BIT[t];
      serve_lowest();
    endfunction

    function void soft_clear();
      status  = (status & ~SOFT_CLR) | SOFT_SET;
      pending = PENDING_RESET;
      foreach (period[t]) begin
        period[t]    = '0;
        remaining[t] = '0;
        running[t]   = 1'b0;
      end
    endfunction

    function void predict_beat(in_beat_t b);
      out_beat_t beat_out;
      byte_t     rd;
      bit        strobe;
      int        t;
      rd     = '0;
      strobe = 1'b0;
      kind_count[b.operation]++;
      case (b.operation)
        OP_READ: begin
          case (b.address)
            ADDR_SERIAL:  status[STAT_SER_BIT] = 1'b0;
            ADDR_PORT_IN: rd = b.port_in;
            ADDR_VECTOR: begin
              rd                   = vector;
              status[STAT_INT_BIT] = 1'b0;
            end
            ADDR_STATUS:  rd = status;
            ADDR_COMMAND: rd = command;
            ADDR_RATE:    rd = rate;
            ADDR_MASK:    rd = mask;
            default: ;
          endcase
        end
        OP_WRITE: begin
          if (b.address == ADDR_COMMAND) begin
            command = b.write_data & CMD_KEEP;
            if (b.write_data[CMD_SOFT_BIT]) soft_clear();
          end else if (b.address == ADDR_RATE) begin
            rate = b.write_data;
          end else if (b.address == ADDR_PORT_OUT) begin
            out_latch = b.write_data;
            strobe    = 1'b1;
          end else if (b.address == ADDR_MASK) begin
            mask = b.write_data;
          end else if (b.address >= ADDR_TIMER0 && b.address < ADDR_TIMER0 + NUM_TIMERS) begin
            t         = int'(b.address - ADDR_TIMER0);
            period[t] = b.write_data;
            if (b.write_data != '0) begin
              remaining[t] = b.write_data;
              running[t]   = 1'b1;
            end else begin
              running[t]   = 1'b0;
              remaining[t] = '0;
              fire_timer(t);
            end
          end
        end
        OP_TICK: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (running[i]) begin
              if (remaining[i] > 1) begin
                remaining[i]--;
              end else begin
                remaining[i] = period[i];
                fire_timer(i);
              end
            end
          end
        end
        OP_SENSOR: begin
          pending[PEND_SENS_BIT] = !sensor_prev && b.level;
          sensor_prev            = b.level;
          if (pending[PEND_SENS_BIT]) serve_lowest();
        end
        OP_PIN7: begin
          if (command[CMD_PIN7_BIT]) pending[PEND_PIN7_BIT] = !pin7_prev && b.level;
          pin7_prev = b.level;
          if (pending[PEND_PIN7_BIT]) serve_lowest();
        end
        default: ;
      endcase
      beat_out.read_data       = rd;
      beat_out.port_out        = out_latch;
      beat_out.port_out_strobe = strobe;
      beat_out.irq_line        = irq_level;
      beat_out.irq_vector      = vector;
      expected_results.push_back(beat_out);
    endfunction

    function void compare_field(string name, byte_t want, byte_t got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("port_out", want.port_out, got.port_out);
      compare_field("port_out_strobe", byte_t'(want.port_out_strobe),
                    byte_t'(got.port_out_strobe));
      compare_field("irq_line", byte_t'(want.irq_line), byte_t'(got.irq_line));
      compare_field("irq_vector", want.irq_vector, got.irq_vector);
    endfunction
  endclass

  // run shape
  localparam int RANDOM_BEATS = 1600;
  localparam int QUIET_FROM   = 1400;  // no gaps on either side from here on
  localparam int HOLD_AT      = 400;   // beat index that triggers the long sink hold
  localparam int PAUSE_AT     = 900;   // beat index where the sender drains the block
  localparam int LONG_HOLD    = 64;
  localparam int STALL_LIMIT  = 2000;

  // operation codes the block does not define
  localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
  // offsets with no register behind them
  localparam logic [ADDR_W-1:0] ADDR_GAP    = 4'd6;
  localparam logic [ADDR_W-1:0] ADDR_LAST   = 4'd15;
  // command bytes
  localparam byte_t CMD_ACK_ON  = byte_t'(1 << CMD_ACK_BIT);
  localparam byte_t CMD_PIN7_ON = byte_t'(1 << CMD_PIN7_BIT);

  logic clk;
  logic rst_n;

  iotu_in_if  in_chan();
  iotu_out_if out_chan();

  io_controller_interrupt_timer_unit_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  irq_timer_scoreboard sb = new();

  bit          quiet        = 1'b0;  // last stretch runs without gaps
  bit          gaps_on      = 1'b1;  // random gaps enabled for this stretch
  bit          hold_req     = 1'b0;  // sender asks the sink for one long hold
  int unsigned stall_cycles = 0;

  // 4-unit clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic in_beat_t make_beat(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                         byte_t data, logic lvl, byte_t port);
    in_beat_t b;
    b.operation  = op;
    b.address    = addr;
    b.write_data = data;
    b.level      = lvl;
    b.port_in    = port;
    return b;
  endfunction

  // weighted request mix: mostly register traffic that drives timers and
  // interrupts, a little noise on unused offsets and undefined operations
  function automatic in_beat_t random_beat();
    in_beat_t    b;
    int unsigned pick;
    int unsigned sel;
    b.address    = ADDR_W'($urandom);
    b.write_data = byte_t'($urandom);
    b.level      = 1'($urandom);
    b.port_in    = byte_t'($urandom);
    pick         = $urandom_range(0, 99);
    if (pick < 22) begin
      b.operation = OP_READ;
      if ($urandom_range(0, 2) == 0) b.address = $urandom_range(0, 1) ? ADDR_VECTOR : ADDR_STATUS;
    end else if (pick < 52) begin
      b.operation = OP_WRITE;
      sel         = $urandom_range(0, 19);
      if (sel < 3) begin
        // soft reset only now and then, so timers get time to run
        b.address                  = ADDR_COMMAND;
        b.write_data[CMD_SOFT_BIT] = ($urandom_range(0, 5) == 0);
      end else if (sel < 6) begin
        b.address = ADDR_MASK;
        if ($urandom_range(0, 4) == 0) b.write_data = 8'hFF;
      end else if (sel < 13) begin
        // short periods so expiries are frequent
        b.address = ADDR_TIMER0 + ADDR_W'($urandom_range(0, NUM_TIMERS - 1));
        sel       = $urandom_range(0, 9);
        if (sel < 2) b.write_data = '0;
        else if (sel < 8) b.write_data = byte_t'($urandom_range(1, 6));
      end else if (sel < 15) begin
        b.address = ADDR_RATE;
      end else if (sel < 17) begin
        b.address = ADDR_PORT_OUT;
      end
    end else if (pick < 80) begin
      b.operation = OP_TICK;
    end else if (pick < 88) begin
      b.operation = OP_SENSOR;
    end else if (pick < 96) begin
      b.operation = OP_PIN7;
    end else begin
      b.operation = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return b;
  endfunction

  // drive one request beat and hold it until the block takes it
  task automatic send_beat(input in_beat_t b);
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= b.operation;
    in_chan.address    <= b.address;
    in_chan.write_data <= b.write_data;
    in_chan.level      <= b.level;
    in_chan.port_in    <= b.port_in;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.predict_beat(b);
  endtask

  // occasional idle burst on the request side
  task automatic sender_gap();
    if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // request side: reset, directed beats, random traffic, end of run
  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= '0;
    in_chan.address    <= '0;
    in_chan.write_data <= '0;
    in_chan.level      <= 1'b0;
    in_chan.port_in    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, the serial buffer and the input port at all ones
    send_beat(make_beat(OP_READ, ADDR_STATUS, 8'h00, 1'b0, 8'hFF));
    send_beat(make_beat(OP_READ, ADDR_PORT_IN, 8'hFF, 1'b1, 8'hFF));
    send_beat(make_beat(OP_READ, ADDR_SERIAL, 8'h00, 1'b0, 8'h00));
    // enable everything, then a zero period fires timer 0 at once
    send_beat(make_beat(OP_WRITE, ADDR_MASK, 8'hFF, 1'b0, 8'h00));
    send_beat(make_beat(OP_WRITE, ADDR_TIMER0, 8'h00, 1'b0, 8'h00));
    // vector read clears the interrupt status bit
    send_beat(make_beat(OP_READ, ADDR_VECTOR, 8'h00, 1'b0, 8'h00));
    // acknowledge mode: expiries drive the line
    send_beat(make_beat(OP_WRITE, ADDR_COMMAND, CMD_ACK_ON, 1'b0, 8'h00));
    send_beat(make_beat(OP_WRITE, ADDR_TIMER0 + 4'd1, 8'h02, 1'b0, 8'h00));
    send_beat(make_beat(OP_TICK, ADDR_SERIAL, 8'h00, 1'b0, 8'h00));
    send_beat(make_beat(OP_TICK, ADDR_SERIAL, 8'h00, 1'b0, 8'h00));
    // sensor rising edge, then a steady high level clears the bit
    send_beat(make_beat(OP_SENSOR, ADDR_SERIAL, 8'h00, 1'b1, 8'h00));
    send_beat(make_beat(OP_SENSOR, ADDR_SERIAL, 8'h00, 1'b1, 8'h00));
    // pin-7 select: rising pin edge sets bit 7, timer 4 sets nothing
    send_beat(make_beat(OP_WRITE, ADDR_COMMAND, CMD_ACK_ON | CMD_PIN7_ON, 1'b0, 8'h00));
    send_beat(make_beat(OP_PIN7, ADDR_SERIAL, 8'h00, 1'b1, 8'h00));
    send_beat(make_beat(OP_WRITE, ADDR_TIMER0 + 4'd4, 8'h00, 1'b0, 8'h00));
    // parallel output strobes at both extremes
    send_beat(make_beat(OP_WRITE, ADDR_PORT_OUT, 8'hFF, 1'b0, 8'h00));
    send_beat(make_beat(OP_WRITE, ADDR_PORT_OUT, 8'h00, 1'b0, 8'h00));
    send_beat(make_beat(OP_WRITE, ADDR_RATE, 8'hA5, 1'b0, 8'h00));
    send_beat(make_beat(OP_READ, ADDR_RATE, 8'h00, 1'b0, 8'h00));
    // all-ones command: soft reset plus every kept bit
    send_beat(make_beat(OP_WRITE, ADDR_COMMAND, 8'hFF, 1'b0, 8'h00));
    send_beat(make_beat(OP_READ, ADDR_COMMAND, 8'h00, 1'b0, 8'h00));
    // unused offsets and undefined operations
    send_beat(make_beat(OP_READ, ADDR_LAST, 8'h00, 1'b0, 8'hFF));
    send_beat(make_beat(OP_WRITE, ADDR_GAP, 8'hFF, 1'b0, 8'h00));
    send_beat(make_beat(OP_SPARE_LO, ADDR_LAST, 8'hFF, 1'b1, 8'hFF));
    send_beat(make_beat(OP_SPARE_HI, ADDR_LAST, 8'hFF, 1'b1, 8'hFF));

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      quiet = (n >= QUIET_FROM);
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        // stop offering until every outstanding result is back
        in_chan.valid <= 1'b0;
        wait_results_drained();
      end
      send_beat(random_beat());
      sender_gap();
    end
    in_chan.valid <= 1'b0;

    // drain, then wait for any stray beat
    wait_results_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d reads, %0d writes, %0d ticks, %0d sensor and %0d pin-7 beats",
             sb.kind_count[OP_READ], sb.kind_count[OP_WRITE], sb.kind_count[OP_TICK],
             sb.kind_count[OP_SENSOR], sb.kind_count[OP_PIN7]);
    $display("%0d interrupts served, %0d result beats checked, %0d mismatches",
             sb.served, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: check every taken beat, random stalls plus one long hold
  initial begin
    out_beat_t   got;
    int unsigned idle_left;
    out_chan.ready <= 1'b0;
    idle_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got.read_data       = out_chan.read_data;
        got.port_out        = out_chan.port_out;
        got.port_out_strobe = out_chan.port_out_strobe;
        got.irq_line        = out_chan.irq_line;
        got.irq_vector      = out_chan.irq_vector;
        sb.check_result(got);
      end
      // long hold fills the block so it must push back on requests
      if (hold_req) begin
        hold_req  = 1'b0;
        idle_left = LONG_HOLD;
      end else if (idle_left == 0 && !quiet && gaps_on && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(1, 5);
      end
      if (idle_left != 0) begin
        out_chan.ready <= 1'b0;
        idle_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog: too many cycles without any beat on either channel
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
